FILE: design/lsfs_pkg.sv
package lsfs_pkg;

    // Configuration register indexes
    localparam logic CFG_LED_COUNT = 1'b0;
    localparam logic CFG_HALF_PERIOD = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 11;
    localparam int COUNT_W = 11;

    localparam logic [COUNT_W-1:0] LED_COUNT_RESET = 11'd30;

    // Top three bits of every LED word
    localparam logic [2:0] LED_HEADER = 3'b111;

    localparam int WORD_W = 32;
    localparam int BIT_IDX_W = 5;

    // One LED as the front hands it to the serializer
    typedef struct packed {
        logic lead;                // start frame goes out first
        logic tail;                // end frame follows this LED
        logic [WORD_W-1:0] word;   // header+brightness, blue, green, red
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: design/lsfs_front.sv
module lsfs_front #(
    parameter int MAX_LEDS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsfs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [31:0]                      i_s_axis_tdata,
    input  lsfs_pkg::t_q_stat                i_q_stat,
    output logic                             o_push,
    output lsfs_pkg::t_job                   o_job
);

    localparam int PW = $clog2(MAX_LEDS);
    localparam int CW = (PW + 1 > lsfs_pkg::COUNT_W) ? PW + 1 : lsfs_pkg::COUNT_W;

    logic [lsfs_pkg::COUNT_W-1:0] r_led_count;
    logic [PW-1:0]                r_position;
    logic [PW-1:0]                n_position;
    logic [CW-1:0]                w_cnt_raw;
    logic [CW-1:0]                w_cnt_max;
    logic [CW-1:0]                w_cnt_eff;
    logic [CW-1:0]                w_pos_inc;
    logic                         w_tail;
    logic                         w_accept;

    assign o_cfg_ready = 1'b1;

    // Only led_count is stored; half-period writes are accepted and dropped, so beats do not depend on it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= lsfs_pkg::LED_COUNT_RESET;
        end else if (i_cfg_valid && i_cfg_index == lsfs_pkg::CFG_LED_COUNT) begin
            r_led_count <= i_cfg_data[lsfs_pkg::COUNT_W-1:0];
        end
    end

    // Clamp the count into the legal range
    always_comb begin
        w_cnt_raw = CW'(r_led_count);
        w_cnt_max = CW'(MAX_LEDS);
        if (w_cnt_raw < CW'(2)) begin
            w_cnt_eff = CW'(2);
        end else if (w_cnt_raw > w_cnt_max) begin
            w_cnt_eff = w_cnt_max;
        end else begin
            w_cnt_eff = w_cnt_raw;
        end
    end

    assign w_pos_inc = CW'(r_position) + CW'(1);
    assign w_tail = (w_pos_inc >= w_cnt_eff);

    assign o_s_axis_tready = !i_q_stat.full;
    assign w_accept = i_s_axis_tvalid && !i_q_stat.full;

    always_comb begin
        n_position = r_position;
        if (w_accept) begin
            n_position = w_tail ? '0 : w_pos_inc[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
        end else begin
            r_position <= n_position;
        end
    end

    assign o_push = w_accept;
    assign o_job.lead = (r_position == '0);
    assign o_job.tail = w_tail;
    assign o_job.word = {lsfs_pkg::LED_HEADER, i_s_axis_tdata[7:3],
                         i_s_axis_tdata[31:24], i_s_axis_tdata[23:16],
                         i_s_axis_tdata[15:8]};

endmodule

FILE: design/lsfs_queue.sv
module lsfs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lsfs_pkg::t_job    i_job,
    input  logic              i_pop,
    output lsfs_pkg::t_job    o_head,
    output lsfs_pkg::t_q_stat o_stat
);

    lsfs_pkg::t_job r_slot [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_head = r_slot[r_rd];
    assign o_stat.full = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

FILE: design/lsfs_back.sv
module lsfs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsfs_pkg::t_job    i_head,
    input  lsfs_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,
    output logic              o_m_axis_tlast,
    output logic              o_m_axis_tuser
);

    localparam logic [1:0] SEG_START = 2'd0;
    localparam logic [1:0] SEG_LED   = 2'd1;
    localparam logic [1:0] SEG_END   = 2'd2;

    logic [1:0]                    r_seg;
    logic [1:0]                    n_seg;
    logic [1:0]                    w_seg;
    logic [lsfs_pkg::BIT_IDX_W-1:0] r_bit;
    logic [lsfs_pkg::BIT_IDX_W-1:0] n_bit;
    logic                          r_valid;
    logic                          r_data;
    logic                          r_last;
    logic                          r_done;
    logic                          w_step;
    logic                          w_seg_end;
    logic                          w_job_end;
    logic                          w_bit;

    // A job without a start frame enters straight at the LED word
    assign w_seg = (r_seg == SEG_START && !i_head.lead) ? SEG_LED : r_seg;

    assign w_step = !i_q_stat.empty && (!r_valid || i_m_axis_tready);
    assign w_seg_end = (r_bit == '0);
    assign w_job_end = w_seg_end &&
                       (w_seg == SEG_END || (w_seg == SEG_LED && !i_head.tail));

    always_comb begin
        unique case (w_seg)
            SEG_START: w_bit = 1'b0;
            SEG_LED:   w_bit = i_head.word[r_bit];
            SEG_END:   w_bit = 1'b1;
            default:   w_bit = 1'b0;
        endcase
    end

    always_comb begin
        n_seg = r_seg;
        n_bit = r_bit;
        if (w_step) begin
            if (w_job_end) begin
                n_seg = SEG_START;
                n_bit = '1;
            end else if (w_seg_end) begin
                n_seg = w_seg + 2'd1;
                n_bit = '1;
            end else begin
                n_seg = w_seg;
                n_bit = r_bit - lsfs_pkg::BIT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg   <= SEG_START;
            r_bit   <= '1;
            r_valid <= 1'b0;
        end else begin
            r_seg <= n_seg;
            r_bit <= n_bit;
            if (w_step) begin
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_data <= w_bit;
            r_last <= w_job_end;
            r_done <= w_job_end && (w_seg == SEG_END);
        end
    end

    assign o_pop = w_step && w_job_end;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata = {7'd0, r_data};
    assign o_m_axis_tlast = r_last;
    assign o_m_axis_tuser = r_done;

endmodule

FILE: design/led_strip_frame_serializer_unit.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata[7:0] led_level, [15:8] red, [23:16] green, [31:24] blue
// m_axis    out        tdata[0] data_bit (rest zero), tlast last_of_run, tuser frame_done
// cfg       in         index 0 led_count (11 bits), index 1 bit_half_period (8 bits)
//
// One bit leaves the output register per cycle unless m_axis stalls or no LED waits:
// an LED sends its word, with a start frame if first in a frame, an end frame if last.
// A two-entry queue lets the next LED be accepted while the current one shifts out.
// Reset is synchronous, active low; it clears the LED position, so the next LED
// starts a frame, and restores led_count to 30.
// A stalled m_axis holds its beat and the serializer; s_axis stalls only on a full queue.
module led_strip_frame_serializer_unit #(
    parameter int MAX_LEDS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsfs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // led_level[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [31:0]                      i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // data_bit[0], zero fill [7:1]
    output logic [7:0]                       o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    // frame_done[0]
    output logic                             o_m_axis_tuser
);

    lsfs_pkg::t_job    w_push_job;
    lsfs_pkg::t_job    w_head;
    lsfs_pkg::t_q_stat w_q_stat;
    logic              w_push;
    logic              w_pop;

    // Front: hold the config, classify each LED and pack its word
    lsfs_front #(
        .MAX_LEDS(MAX_LEDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_stat        (w_q_stat),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    // Queue: decouple acceptance from shifting
    lsfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back: shift start frame, LED word and end frame out MSB first
    lsfs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

FILE: design/lsfs_checker.sv
module lsfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic       o_m_axis_tuser
);

    // A stalled beat stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // The end of a frame always closes the run of its LED
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("frame_done without last_of_run");

    // The last bit of the end frame is a one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[0])
        else $error("frame_done on a zero bit");

    // Reset empties the output register
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind led_strip_frame_serializer_unit lsfs_checker u_lsfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int          CLK_PERIOD        = 12;
    localparam int          SETTLE_CYCLES     = 8;
    localparam int          TAIL_CYCLES       = 40;
    localparam int          MAX_STRIP         = 1024;
    localparam int          RANDOM_PHASES     = 8;
    localparam int          LEDS_PER_PHASE    = 50;
    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd5;

    // One serial bit as it should leave the output channel
    typedef struct packed {
        logic data;
        logic last;
        logic done;
    } t_strip_bit;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [lsfs_pkg::CFG_INDEX_W-1:0] i_cfg_index = lsfs_pkg::CFG_LED_COUNT;
    logic [lsfs_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    // led_level[7:0], red[15:8], green[23:16], blue[31:24]
    logic [31:0]                      i_s_axis_tdata = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    // data_bit[0], zero fill [7:1]
    logic [7:0]                       o_m_axis_tdata;
    logic                             o_m_axis_tlast;
    // frame_done[0]
    logic                             o_m_axis_tuser;

    led_strip_frame_serializer_unit #(
        .MAX_LEDS(MAX_STRIP)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Shadow of the block: register copies and the position inside the frame
    logic [lsfs_pkg::COUNT_W-1:0] shadow_led_count;
    logic [7:0]         shadow_half_period;   // never changes the bits
    int unsigned        strip_pos = 0;

    t_strip_bit         pending_bits[$];      // serial bits still owed by the block
    logic [31:0]        led_backlog[$];       // LED beats not yet offered
    int unsigned        leds_queued = 0;
    int unsigned        leds_taken = 0;
    int unsigned        cfg_beats = 0;
    int unsigned        mismatches = 0;
    logic               s_fire = 1'b0;
    bit                 calm = 1'b0;          // no idling on either side while set
    int                 send_gap = 0;
    int                 stall_left = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(80_000_000);
        $display("FAILURE");
        $finish;
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 96)
            return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    function automatic logic [31:0] pack_led(input logic [7:0] level, input logic [7:0] red,
                                             input logic [7:0] green, input logic [7:0] blue);
        return {blue, green, red, level};
    endfunction

    // Random colors, with each byte pinned to an extreme now and then
    function automatic logic [31:0] random_led();
        logic [31:0] v;
        v = $urandom();
        for (int k = 0; k < 4; k++)
            if ($urandom_range(0, 9) == 0)
                v[k*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return v;
    endfunction

    function automatic void owe_word(input logic [31:0] word);
        for (int b = 31; b >= 0; b--)
            pending_bits.push_back('{data: word[b], last: 1'b0, done: 1'b0});
    endfunction

    // Expected bit stream for one LED beat: optional start frame, LED word,
    // optional end frame; tlast on its final bit, tuser on the end frame's last bit
    function automatic void serialize_led(input logic [31:0] beat);
        logic [7:0]  level;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        int unsigned frame_len;
        logic        closes_frame;
        level = beat[7:0];
        red   = beat[15:8];
        green = beat[23:16];
        blue  = beat[31:24];
        frame_len = 32'(shadow_led_count);
        if (frame_len < 2)
            frame_len = 2;
        if (frame_len > MAX_STRIP)
            frame_len = MAX_STRIP;
        if (strip_pos == 0)
            owe_word(32'h0000_0000);
        owe_word({lsfs_pkg::LED_HEADER, level[7:3], blue, green, red});
        // A count shrunk below the position also closes the frame here
        closes_frame = (strip_pos + 1 >= frame_len);
        if (closes_frame) begin
            owe_word(32'hFFFF_FFFF);
            strip_pos = 0;
        end else begin
            strip_pos++;
        end
        pending_bits[pending_bits.size()-1].last = 1'b1;
        pending_bits[pending_bits.size()-1].done = closes_frame;
    endfunction

    function automatic void check_bit();
        t_strip_bit want;
        if (pending_bits.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: unexpected beat tdata=%h tlast=%b tuser=%b", $realtime,
                         o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
            mismatches++;
            return;
        end
        want = pending_bits.pop_front();
        if (o_m_axis_tdata !== {7'b0, want.data} || o_m_axis_tlast !== want.last ||
            o_m_axis_tuser !== want.done) begin
            if (mismatches < 10)
                $display("%0t: expected data=%b last=%b done=%b, got tdata=%h tlast=%b tuser=%b",
                         $realtime, want.data, want.last, want.done,
                         o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
            mismatches++;
        end
    endfunction

    // Sample every channel at the rising edge; predict on LED beats, check on bit beats
    always @(posedge i_clk) begin : monitor
        if (!i_rst_n) begin
            shadow_led_count   = lsfs_pkg::LED_COUNT_RESET;
            shadow_half_period = HALF_PERIOD_RESET;
            strip_pos          = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == lsfs_pkg::CFG_LED_COUNT)
                    shadow_led_count = i_cfg_data[lsfs_pkg::COUNT_W-1:0];
                else
                    shadow_half_period = i_cfg_data[7:0];
                cfg_beats++;
            end
            s_fire = i_s_axis_tvalid && o_s_axis_tready;
            if (s_fire) begin
                serialize_led(i_s_axis_tdata);
                leds_taken++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_bit();
        end
    end

    // Offer backlog beats, with random gaps after each accepted beat
    always @(negedge i_clk) begin : sender
        logic        nxt_valid;
        logic [31:0] nxt_data;
        nxt_valid = i_s_axis_tvalid;
        nxt_data  = i_s_axis_tdata;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && s_fire)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (led_backlog.size() != 0) begin
                    nxt_data  = led_backlog.pop_front();
                    nxt_valid = 1'b1;
                    send_gap  = (!calm && $urandom_range(0, 99) < 35) ? idle_len() : 0;
                end
            end
        end
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= nxt_data;
    end

    // Back-pressure on the bit stream, independent of tvalid
    always @(negedge i_clk) begin : receiver
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len() - 1;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        i_m_axis_tready <= nxt_ready;
    end

    task automatic queue_led(input logic [31:0] beat);
        led_backlog.push_back(beat);
        leds_queued++;
    endtask

    // Hold until every queued LED is taken and every owed bit has come out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (leds_taken != leds_queued || pending_bits.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lsfs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lsfs_pkg::CFG_DATA_W-1:0] val);
        int unsigned seen;
        seen = cfg_beats;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk);
        while (cfg_beats == seen);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned pick;
        logic [lsfs_pkg::CFG_DATA_W-1:0] count_val;
        logic [lsfs_pkg::CFG_DATA_W-1:0] half_val;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings (frame of 30): leave the frame open after three LEDs
        queue_led(pack_led(8'h00, 8'h00, 8'h00, 8'h00));
        queue_led(pack_led(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        queue_led(pack_led(8'hA5, 8'h5A, 8'hA5, 8'h5A));
        wait_drained();

        // Shrink the count below the open position: next LED closes the frame
        write_reg(lsfs_pkg::CFG_LED_COUNT, 11'd2);
        write_reg(lsfs_pkg::CFG_HALF_PERIOD, 11'd1);
        queue_led(pack_led(8'h07, 8'h80, 8'h01, 8'h00));
        queue_led(pack_led(8'h08, 8'h01, 8'h80, 8'hFF));
        queue_led(pack_led(8'hF8, 8'hAA, 8'h55, 8'hAA));
        queue_led(pack_led(8'h55, 8'h55, 8'hAA, 8'h55));
        queue_led(pack_led(8'hAA, 8'h00, 8'hFF, 8'h80));
        queue_led(pack_led(8'h80, 8'hFF, 8'h00, 8'h01));
        wait_drained();

        // Counts below range act as two
        write_reg(lsfs_pkg::CFG_LED_COUNT, 11'd0);
        write_reg(lsfs_pkg::CFG_HALF_PERIOD, 11'd255);
        queue_led(pack_led(8'hFF, 8'h12, 8'h34, 8'h56));
        queue_led(pack_led(8'h00, 8'hFE, 8'hDC, 8'hBA));
        queue_led(pack_led(8'h1F, 8'h7F, 8'hFE, 8'h01));
        wait_drained();
        write_reg(lsfs_pkg::CFG_LED_COUNT, 11'd1);
        queue_led(pack_led(8'hE0, 8'h0F, 8'hF0, 8'h3C));
        queue_led(pack_led(8'h3C, 8'hC3, 8'h0F, 8'hF0));
        wait_drained();

        // Count above range clamps to the maximum; full-width writes on both registers
        write_reg(lsfs_pkg::CFG_LED_COUNT, 11'h7FF);
        write_reg(lsfs_pkg::CFG_HALF_PERIOD, 11'h7FF);
        queue_led(pack_led(8'hFF, 8'hFF, 8'h00, 8'h00));
        queue_led(pack_led(8'h00, 8'h00, 8'hFF, 8'h00));
        queue_led(pack_led(8'h77, 8'h00, 8'h00, 8'hFF));
        wait_drained();
        write_reg(lsfs_pkg::CFG_LED_COUNT, 11'd1024);
        queue_led(pack_led(8'h99, 8'h66, 8'h99, 8'h66));
        wait_drained();
        write_reg(lsfs_pkg::CFG_LED_COUNT, 11'd3);
        queue_led(pack_led(8'h01, 8'h02, 8'h04, 8'h08));
        queue_led(pack_led(8'h10, 8'h20, 8'h40, 8'h80));
        queue_led(pack_led(8'hFE, 8'hFD, 8'hFB, 8'hF7));
        wait_drained();

        // Random phases: new settings each time, mostly short frames
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                count_val = 11'($urandom_range(0, 1));
            else if (pick == 1)
                count_val = 11'd2;
            else if (pick == 2)
                count_val = 11'($urandom_range(1000, 2047));
            else
                count_val = 11'($urandom_range(3, 40));
            half_val = 11'($urandom_range(0, 2047));
            if ($urandom_range(0, 1))
                write_reg(lsfs_pkg::CFG_HALF_PERIOD, half_val);
            write_reg(lsfs_pkg::CFG_LED_COUNT, count_val);
            if (!$urandom_range(0, 1))
                write_reg(lsfs_pkg::CFG_HALF_PERIOD, half_val);
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < LEDS_PER_PHASE; n++) begin
                // Pause the sender mid-phase until the stream has fully drained
                if (phase == 3 && n == LEDS_PER_PHASE / 2)
                    wait_drained();
                queue_led(random_led());
            end
            wait_drained();
        end
        calm = 1'b0;

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_bits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
